// ----- rtl/aabb_matrix_transform_assert.svh -----
// Assertion macros used by the box transform top level.
`ifndef AABB_MATRIX_TRANSFORM_ASSERT_SVH
`define AABB_MATRIX_TRANSFORM_ASSERT_SVH
// Implication checked on every rising clock edge outside reset.
`define AMT_ASSERT_IMP(label, clk, rst_n, a, c, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) else $error(msg);
// Next-cycle implication.
`define AMT_ASSERT_NXT(label, clk, rst_n, a, c, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) else $error(msg);
`endif

// ----- rtl/amt_pkg.sv -----
//------------------------------------------------------------------------------
// amt_pkg
// Shared constants and types of the box transform.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
package amt_pkg;
    localparam int CORNER_COUNT = 8;
    localparam int REG_COUNT    = 8;
    localparam int REG_W        = 64;
    localparam int IDX_W        = 3;
    localparam int SUM_W        = 68;
    localparam int QW           = 32;
    localparam int ITER         = 2;  // bits of quotient per pipeline stage

    localparam logic signed [31:0] Q_MAX = 32'sh7FFFFFFF;
    localparam logic signed [31:0] Q_MIN = 32'sh80000000;

    // One corner result heading into the bounds accumulator.
    typedef struct packed {
        logic              valid;
        logic              first;
        logic              last;
        logic signed [31:0] qx;
        logic signed [31:0] qy;
        logic signed [31:0] qz;
        logic              fault;
    } corner_t;
endpackage
`default_nettype wire

// ----- rtl/aabb_matrix_transform.sv -----
//------------------------------------------------------------------------------
// aabb_matrix_transform
// Transforms an axis-aligned box by a 4x4 Q16.16 matrix with perspective divide.
//------------------------------------------------------------------------------
// Usage: load the matrix through cfg_we/cfg_index/cfg_data (reset gives the
// identity) while the block is idle. Present a box with start high; the
// request is taken when busy is low. The block walks the eight corners
// through a shared pipeline, one corner per cycle: the matrix product, then
// three parallel dividers of 17 stages. The bounds are folded
// as corners leave the dividers, and done pulses for one cycle with the
// result and divide_fault.
// Box throughput is set by the single corner generator.
// busy is high while the generator still has corners of a box to issue
// after the current one, so a new request can be taken with the last corner.
// done is registered from the last corner leaving the dividers.
// Reset clears all valid and control state and loads the identity matrix.
// The receiver cannot stall; results appear exactly once on done.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "aabb_matrix_transform_assert.svh"
module aabb_matrix_transform #(
    parameter int CORNER_COUNT = amt_pkg::CORNER_COUNT
) (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      cfg_we,
    input  wire logic [amt_pkg::IDX_W-1:0] cfg_index,
    input  wire logic [63:0]               cfg_data,
    input  wire logic                      start,
    output logic                           busy,
    input  wire logic signed [31:0]        in_min_x,
    input  wire logic signed [31:0]        in_min_y,
    input  wire logic signed [31:0]        in_min_z,
    input  wire logic signed [31:0]        in_max_x,
    input  wire logic signed [31:0]        in_max_y,
    input  wire logic signed [31:0]        in_max_z,
    output logic                           done,
    output logic signed [31:0]             out_min_x,
    output logic signed [31:0]             out_min_y,
    output logic signed [31:0]             out_min_z,
    output logic signed [31:0]             out_max_x,
    output logic signed [31:0]             out_max_y,
    output logic signed [31:0]             out_max_z,
    output logic                           divide_fault
);
    localparam int CW = $clog2(CORNER_COUNT);
    localparam int LAT = 2 + amt_pkg::QW / amt_pkg::ITER + 1;

    logic [63:0] mat_reg [amt_pkg::REG_COUNT];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mat_reg[0] <= 64'd65536;
            mat_reg[1] <= 64'd0;
            mat_reg[2] <= 64'd281474976710656;
            mat_reg[3] <= 64'd0;
            mat_reg[4] <= 64'd0;
            mat_reg[5] <= 64'd65536;
            mat_reg[6] <= 64'd0;
            mat_reg[7] <= 64'd281474976710656;
        end
        else if (cfg_we)
        begin
            mat_reg[cfg_index] <= cfg_data;
        end
    end

    // Corner generator.
    logic              gen_reg;
    logic [CW-1:0]     cnt_reg;
    logic signed [31:0] lo_reg [3];
    logic signed [31:0] hi_reg [3];
    logic              accept;
    assign busy   = gen_reg && (cnt_reg != CW'(CORNER_COUNT - 1));
    assign accept = start && !busy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gen_reg <= 1'b0;
            cnt_reg <= '0;
        end
        else if (accept)
        begin
            gen_reg <= 1'b1;
            cnt_reg <= '0;
        end
        else if (gen_reg)
        begin
            cnt_reg <= cnt_reg + 1'b1;
            if (cnt_reg == CW'(CORNER_COUNT - 1))
                gen_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            lo_reg[0] <= in_min_x;
            lo_reg[1] <= in_min_y;
            lo_reg[2] <= in_min_z;
            hi_reg[0] <= in_max_x;
            hi_reg[1] <= in_max_y;
            hi_reg[2] <= in_max_z;
        end
    end

    // Corner tags follow the arithmetic pipe.
    logic first_pipe_reg [LAT];
    logic last_pipe_reg  [LAT];
    always_ff @(posedge clk)
    begin
        first_pipe_reg[0] <= (cnt_reg == '0);
        last_pipe_reg[0]  <= (cnt_reg == CW'(CORNER_COUNT - 1));
        for (int s = 1; s < LAT; s++)
        begin
            first_pipe_reg[s] <= first_pipe_reg[s-1];
            last_pipe_reg[s]  <= last_pipe_reg[s-1];
        end
    end

    logic                             xv;
    logic signed [amt_pkg::SUM_W-1:0] t [4];

    amt_xform u_xform (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (gen_reg),
        .mat       (mat_reg),
        .px        (cnt_reg[0] ? hi_reg[0] : lo_reg[0]),
        .py        (cnt_reg[1] ? hi_reg[1] : lo_reg[1]),
        .pz        (cnt_reg[2] ? hi_reg[2] : lo_reg[2]),
        .out_valid (xv),
        .t         (t)
    );

    logic              dv [3];
    logic signed [31:0] dq [3];
    logic              df [3];

    for (genvar a = 0; a < 3; a++)
    begin : g_div
        amt_div u_div (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (xv),
            .num       (t[a]),
            .den       (t[3]),
            .out_valid (dv[a]),
            .quot      (dq[a]),
            .fault     (df[a])
        );
    end

    amt_pkg::corner_t cr;
    assign cr.valid = dv[0];
    assign cr.first = first_pipe_reg[LAT-1];
    assign cr.last  = last_pipe_reg[LAT-1];
    assign cr.qx    = dq[0];
    assign cr.qy    = dq[1];
    assign cr.qz    = dq[2];
    assign cr.fault = df[0] | df[1] | df[2];

    // Bounds accumulator.
    logic signed [31:0] mn_reg [3];
    logic signed [31:0] mx_reg [3];
    logic               flt_reg;
    logic               done_reg;
    logic signed [31:0] q [3];
    assign q[0] = cr.qx;
    assign q[1] = cr.qy;
    assign q[2] = cr.qz;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= cr.valid && cr.last;
    end

    always_ff @(posedge clk)
    begin
        if (cr.valid)
        begin
            for (int a = 0; a < 3; a++)
            begin
                if (cr.first || q[a] < mn_reg[a])
                    mn_reg[a] <= q[a];
                if (cr.first || q[a] > mx_reg[a])
                    mx_reg[a] <= q[a];
            end
            flt_reg <= cr.first ? cr.fault : (flt_reg | cr.fault);
        end
    end

    assign done         = done_reg;
    assign out_min_x    = mn_reg[0];
    assign out_min_y    = mn_reg[1];
    assign out_min_z    = mn_reg[2];
    assign out_max_x    = mx_reg[0];
    assign out_max_y    = mx_reg[1];
    assign out_max_z    = mx_reg[2];
    assign divide_fault = flt_reg;

    `AMT_ASSERT_IMP(a_div_lanes, clk, rst_n, 1'b1, (dv[0] == dv[1]) && (dv[1] == dv[2]), "divider lanes out of step")
    `AMT_ASSERT_NXT(a_no_accept_busy, clk, rst_n, accept, busy, "generator did not start")
    `AMT_ASSERT_NXT(a_done_pulse, clk, rst_n, done, !done, "done lasted two cycles")
endmodule
`default_nettype wire

// ----- rtl/amt_div.sv -----
//------------------------------------------------------------------------------
// amt_div
// Pipelined signed Q36.32 / Q36.32 divider giving a saturated Q16.16 quotient.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module amt_div #(
    parameter int SW = amt_pkg::SUM_W
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    input  wire logic signed [SW-1:0] num,
    input  wire logic signed [SW-1:0] den,
    output logic                      out_valid,
    output logic signed [31:0]        quot,
    output logic                      fault
);
    // The quotient of |num|<<16 by |den| is only of interest up to 2^32;
    // larger is saturation. Comparing against d<<32 up front flags it, then
    // 32 restoring steps produce the low quotient bits, two per stage.
    localparam int NSTG = amt_pkg::QW / amt_pkg::ITER;
    localparam int NW   = SW + 16;
    localparam int RW   = SW + 1;

    logic          v_reg   [NSTG+1];
    logic [NW-1:0] n_reg   [NSTG+1];
    logic [SW-1:0] d_reg   [NSTG+1];
    logic [RW-1:0] r_reg   [NSTG+1];
    logic [31:0]   q_reg   [NSTG+1];
    logic          neg_reg [NSTG+1];
    logic          ovf_reg [NSTG+1];
    logic          dz_reg  [NSTG+1];
    logic          nz_reg  [NSTG+1];

    logic [SW-1:0] an, ad;
    logic [NW-1:0] n0;
    assign an = num[SW-1] ? SW'(-num) : SW'(num);
    assign ad = den[SW-1] ? SW'(-den) : SW'(den);
    assign n0 = {an, 16'd0};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int s = 0; s <= NSTG; s++)
            begin
                v_reg[s] <= 1'b0;
            end
        end
        else
        begin
            v_reg[0] <= in_valid;
            for (int s = 1; s <= NSTG; s++)
            begin
                v_reg[s] <= v_reg[s-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        // Stage 0: magnitudes, sign, and the high part of the numerator
        // (bits above 32) reduced into the starting remainder.
        n_reg[0]   <= n0;
        d_reg[0]   <= ad;
        neg_reg[0] <= num[SW-1] ^ den[SW-1];
        dz_reg[0]  <= (den == '0);
        nz_reg[0]  <= (num == '0);
        // Quotient >= 2^32 exactly when (n >> 32) >= d.
        ovf_reg[0] <= ({{(RW-(NW-32)){1'b0}}, n0[NW-1:32]} >= {1'b0, ad});
        r_reg[0]   <= {{(RW-(NW-32)){1'b0}}, n0[NW-1:32]};
        q_reg[0]   <= '0;
        for (int s = 1; s <= NSTG; s++)
        begin
            logic [RW-1:0] r;
            logic [31:0]   q;
            r = r_reg[s-1];
            q = q_reg[s-1];
            for (int k = 0; k < amt_pkg::ITER; k++)
            begin
                // Remainder is kept below d only when not overflowing;
                // an overflowing item's low bits are discarded anyway.
                r = {r[RW-2:0], n_reg[s-1][31 - ((s-1)*amt_pkg::ITER + k)]};
                if (r >= {1'b0, d_reg[s-1]})
                begin
                    r = r - {1'b0, d_reg[s-1]};
                    q = {q[30:0], 1'b1};
                end
                else
                begin
                    q = {q[30:0], 1'b0};
                end
            end
            r_reg[s]   <= ovf_reg[s-1] ? r_reg[s-1] : r;
            q_reg[s]   <= q;
            n_reg[s]   <= n_reg[s-1];
            d_reg[s]   <= d_reg[s-1];
            neg_reg[s] <= neg_reg[s-1];
            ovf_reg[s] <= ovf_reg[s-1];
            dz_reg[s]  <= dz_reg[s-1];
            nz_reg[s]  <= nz_reg[s-1];
        end
    end

    logic [31:0] qf;
    assign qf = q_reg[NSTG];

    always_comb
    begin
        fault = 1'b0;
        quot  = '0;
        if (dz_reg[NSTG])
        begin
            fault = 1'b1;
            if (nz_reg[NSTG])
                quot = '0;
            else
                quot = neg_reg[NSTG] ? amt_pkg::Q_MIN : amt_pkg::Q_MAX;
        end
        else if (neg_reg[NSTG])
        begin
            if (ovf_reg[NSTG] || qf > 32'h80000000)
            begin
                fault = 1'b1;
                quot  = amt_pkg::Q_MIN;
            end
            else
                quot = -$signed(qf);
        end
        else
        begin
            if (ovf_reg[NSTG] || qf[31])
            begin
                fault = 1'b1;
                quot  = amt_pkg::Q_MAX;
            end
            else
                quot = $signed(qf);
        end
    end

    assign out_valid = v_reg[NSTG];
endmodule
`default_nettype wire

// ----- rtl/amt_xform.sv -----
//------------------------------------------------------------------------------
// amt_xform
// Two-stage matrix-vector product of one homogeneous corner, Q36.32 exact.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module amt_xform (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    input  wire logic [63:0]         mat [amt_pkg::REG_COUNT],
    input  wire logic signed [31:0]  px,
    input  wire logic signed [31:0]  py,
    input  wire logic signed [31:0]  pz,
    output logic                     out_valid,
    output logic signed [amt_pkg::SUM_W-1:0] t [4]
);
    logic signed [63:0] prod_reg [4][4];
    logic               v1_reg, v2_reg;
    logic signed [31:0] p [4];
    assign p[0] = px;
    assign p[1] = py;
    assign p[2] = pz;
    assign p[3] = 32'sd65536;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
        end
    end

    // Sixteen 32x32 products, one register level.
    always_ff @(posedge clk)
    begin
        for (int r = 0; r < 4; r++)
        begin
            for (int c = 0; c < 4; c++)
            begin
                prod_reg[r][c] <= $signed(mat[r*2 + c/2][32*(c%2) +: 32]) * p[c];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        for (int r = 0; r < 4; r++)
        begin
            t[r] <= amt_pkg::SUM_W'(prod_reg[r][0]) + amt_pkg::SUM_W'(prod_reg[r][1])
                  + amt_pkg::SUM_W'(prod_reg[r][2]) + amt_pkg::SUM_W'(prod_reg[r][3]);
        end
    end

    assign out_valid = v2_reg;
endmodule
`default_nettype wire

// ----- sim/tb.sv -----
//------------------------------------------------------------------------------
// tb
// Self-checking bench for the box transform. Directed boxes and random boxes
// are pushed through under several matrices. A local predictor computes each
// transformed box, and every done pulse is compared with the oldest one.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module tb;
    import amt_pkg::*;

    localparam int DRAIN_CYCLES = 40;
    localparam int WATCHDOG_LIMIT = 5000;

    typedef struct {
        logic signed [31:0] lo [3];
        logic signed [31:0] hi [3];
    } box_t;

    typedef struct {
        logic signed [31:0] mn [3];
        logic signed [31:0] mx [3];
        logic               fault;
    } bounds_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               cfg_we = 1'b0;
    logic [IDX_W-1:0]   cfg_index = '0;
    logic [63:0]        cfg_data = '0;
    logic               start = 1'b0;
    logic               busy;
    logic signed [31:0] in_min_x = '0, in_min_y = '0, in_min_z = '0;
    logic signed [31:0] in_max_x = '0, in_max_y = '0, in_max_z = '0;
    logic               done;
    logic signed [31:0] out_min_x, out_min_y, out_min_z;
    logic signed [31:0] out_max_x, out_max_y, out_max_z;
    logic               divide_fault;

    logic [63:0] matrix_shadow [REG_COUNT];
    bounds_t     bounds_queue [$];
    int          err_count = 0;
    int          idle_cycles = 0;

    aabb_matrix_transform uut (
        .clk(clk), .rst_n(rst_n),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .start(start), .busy(busy),
        .in_min_x(in_min_x), .in_min_y(in_min_y), .in_min_z(in_min_z),
        .in_max_x(in_max_x), .in_max_y(in_max_y), .in_max_z(in_max_z),
        .done(done),
        .out_min_x(out_min_x), .out_min_y(out_min_y), .out_min_z(out_min_z),
        .out_max_x(out_max_x), .out_max_y(out_max_y), .out_max_z(out_max_z),
        .divide_fault(divide_fault)
    );

    initial
    begin
        forever #1 clk = ~clk;
    end

    // Q16.16 quotient of two Q36.32 sums, truncated toward zero, saturated.
    function automatic logic signed [31:0] q16_divide(logic signed [127:0] num,
                                                      logic signed [127:0] den,
                                                      inout logic fault);
        logic [127:0] n, d, q;
        logic         neg;
        if (den == 0)
        begin
            fault = 1'b1;
            if (num == 0)
                return 32'sd0;
            return (num < 0) ? Q_MIN : Q_MAX;
        end
        neg = (num < 0) != (den < 0);
        n = (num < 0) ? -num : num;
        d = (den < 0) ? -den : den;
        n = n << 16;
        q = n / d;
        if (neg)
        begin
            if (q > 128'h8000_0000)
            begin
                fault = 1'b1;
                return Q_MIN;
            end
            return -q[31:0];
        end
        if (q > 128'h7FFF_FFFF)
        begin
            fault = 1'b1;
            return Q_MAX;
        end
        return q[31:0];
    endfunction

    function automatic bounds_t transform_box(box_t b);
        bounds_t            res;
        logic signed [127:0] t [4];
        longint             p [4];
        longint             m;
        logic signed [31:0] q;
        res.fault = 1'b0;
        for (int k = 0; k < CORNER_COUNT; k++)
        begin
            for (int a = 0; a < 3; a++)
                p[a] = ((k >> a) & 1) ? longint'(b.hi[a]) : longint'(b.lo[a]);
            p[3] = 65536;
            for (int r = 0; r < 4; r++)
            begin
                t[r] = 0;
                for (int c = 0; c < 4; c++)
                begin
                    m = longint'($signed(matrix_shadow[r*2 + c/2][32*(c%2) +: 32]));
                    t[r] = t[r] + m * p[c];
                end
            end
            for (int a = 0; a < 3; a++)
            begin
                q = q16_divide(t[a], t[3], res.fault);
                if (k == 0 || q < res.mn[a]) res.mn[a] = q;
                if (k == 0 || q > res.mx[a]) res.mx[a] = q;
            end
        end
        return res;
    endfunction

    task automatic write_matrix_reg(int idx, logic [63:0] value);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx[IDX_W-1:0];
        cfg_data <= value;
        matrix_shadow[idx] = value;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic load_matrix(logic [63:0] regs [REG_COUNT]);
        for (int i = 0; i < REG_COUNT; i++)
            write_matrix_reg(i, regs[i]);
    endtask

    // Lower start and wait until every pending result has come back.
    task automatic drain;
        start <= 1'b0;
        while (bounds_queue.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Sends one request. Start is only lowered when a gap is taken, so that
    // back-to-back requests keep it high with a single assignment.
    task automatic send_box(box_t b, int gap);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_min_x <= b.lo[0]; in_min_y <= b.lo[1]; in_min_z <= b.lo[2];
        in_max_x <= b.hi[0]; in_max_y <= b.hi[1]; in_max_z <= b.hi[2];
        start <= 1'b1;
        do
            @(posedge clk);
        while (busy !== 1'b0);
        bounds_queue.push_back(transform_box(b));
    endtask

    function automatic box_t make_box(logic signed [31:0] x0, logic signed [31:0] y0,
                                      logic signed [31:0] z0, logic signed [31:0] x1,
                                      logic signed [31:0] y1, logic signed [31:0] z1);
        box_t b;
        b.lo[0] = x0; b.lo[1] = y0; b.lo[2] = z0;
        b.hi[0] = x1; b.hi[1] = y1; b.hi[2] = z1;
        return b;
    endfunction

    function automatic logic signed [31:0] rand_coord;
        case ($urandom_range(0, 3))
            0: return $urandom;
            1: return $signed($urandom_range(0, 32'h0020_0000)) - 32'sh0010_0000;
            2: return $signed($urandom_range(0, 32'h4000_0000)) - 32'sh2000_0000;
            default: return (($urandom_range(0, 1) == 1) ? Q_MAX : Q_MIN);
        endcase
    endfunction

    function automatic logic [31:0] rand_elem;
        case ($urandom_range(0, 4))
            0: return $urandom;
            1: return 32'd0;
            2: return 32'h0001_0000;
            default: return $signed($urandom_range(0, 32'h0004_0000)) - 32'sh0002_0000;
        endcase
    endfunction

    task automatic run_random_boxes(int count);
        box_t b;
        for (int i = 0; i < count; i++)
        begin
            b = make_box(rand_coord(), rand_coord(), rand_coord(),
                         rand_coord(), rand_coord(), rand_coord());
            if ($urandom_range(0, 2) != 0)
            begin
                // Keep most boxes well ordered.
                for (int a = 0; a < 3; a++)
                    if (b.lo[a] > b.hi[a])
                    begin
                        b.lo[a] = b.lo[a] ^ b.hi[a];
                        b.hi[a] = b.lo[a] ^ b.hi[a];
                        b.lo[a] = b.lo[a] ^ b.hi[a];
                    end
            end
            send_box(b, (i % 100 < 30) ? 0 : $urandom_range(0, 17));
        end
    endtask

    task automatic test_identity_directed;
        send_box(make_box(0, 0, 0, 0, 0, 0), 0);
        send_box(make_box(-32'sh10000, -32'sh20000, -32'sh30000,
                          32'sh10000, 32'sh20000, 32'sh30000), 3);
        send_box(make_box(Q_MIN, Q_MIN, Q_MIN, Q_MAX, Q_MAX, Q_MAX), 0);
        send_box(make_box(Q_MAX, Q_MAX, Q_MAX, Q_MIN, Q_MIN, Q_MIN), 0);
        send_box(make_box(32'sh50000, 1, -1, -32'sh50000, -1, 1), 17);
        send_box(make_box(-1, -1, -1, -1, -1, -1), 0);
        drain();
    endtask

    task automatic test_matrix_extremes;
        logic [63:0] regs [REG_COUNT];
        // All zeros: every w is zero with zero numerators.
        foreach (regs[i]) regs[i] = 64'd0;
        load_matrix(regs);
        send_box(make_box(Q_MIN, 0, 5, Q_MAX, 7, 9), 0);
        drain();
        // Zero w with signed numerators.
        regs[0] = 64'h0000_0000_0001_0000;
        regs[2] = 64'h0001_0000_0000_0000;
        regs[5] = 64'h8000_0000_0001_0000;
        load_matrix(regs);
        send_box(make_box(-32'sh30000, 32'sh20000, 0, 32'sh30000, -32'sh20000, 0), 0);
        send_box(make_box(0, 0, 32'sh1000, 0, 0, 32'sh2000), 2);
        drain();
        // All ones: every element is minus one ulp.
        foreach (regs[i]) regs[i] = '1;
        load_matrix(regs);
        send_box(make_box(Q_MIN, Q_MIN, Q_MIN, Q_MAX, Q_MAX, Q_MAX), 0);
        send_box(make_box(1, 2, 3, 4, 5, 6), 0);
        drain();
        // Largest magnitudes with a tiny w, forcing saturation.
        foreach (regs[i]) regs[i] = 64'h7FFF_FFFF_8000_0000;
        regs[6] = 64'h0000_0000_0000_0000;
        regs[7] = 64'h0000_0001_0000_0000;
        load_matrix(regs);
        send_box(make_box(Q_MAX, Q_MIN, Q_MAX, Q_MIN, Q_MAX, Q_MIN), 0);
        send_box(make_box(32'sh10000, 32'sh10000, 32'sh10000,
                          32'sh20000, 32'sh20000, 32'sh20000), 5);
        drain();
        // Perspective-like matrix with w taken from z.
        regs[0] = 64'h0000_0000_0002_0000;
        regs[1] = 64'h0000_0000_0000_0000;
        regs[2] = 64'h0000_0000_0000_0000;
        regs[3] = 64'h0000_0000_0002_0000;
        regs[4] = 64'h0000_0000_0000_0000;
        regs[5] = 64'hFFFF_0000_0001_8000;
        regs[6] = 64'h0000_0000_0000_0000;
        regs[7] = 64'h0000_0000_FFFF_0000;
        load_matrix(regs);
        send_box(make_box(-32'sh10000, -32'sh10000, 32'sh10000,
                          32'sh10000, 32'sh10000, 32'sh80000), 0);
        send_box(make_box(-32'sh10000, -32'sh10000, -32'sh10000,
                          32'sh10000, 32'sh10000, 32'sh10000), 0);
        drain();
    endtask

    task automatic test_random_matrices;
        logic [63:0] regs [REG_COUNT];
        for (int phase = 0; phase < 8; phase++)
        begin
            foreach (regs[i])
                regs[i] = {rand_elem(), rand_elem()};
            // Mostly an affine bottom row so that w stays at one.
            if (phase % 4 != 3)
            begin
                regs[6] = 64'd0;
                regs[7] = 64'h0001_0000_0000_0000;
            end
            load_matrix(regs);
            run_random_boxes(178);
            drain();
        end
    endtask

    always @(posedge clk)
    begin
        bounds_t e;
        if (rst_n && done === 1'b1)
        begin
            if (bounds_queue.size() == 0)
            begin
                $error("done with no request outstanding");
                err_count++;
            end
            else
            begin
                e = bounds_queue.pop_front();
                if (out_min_x !== e.mn[0])
                begin
                    $error("out_min_x expected %h got %h", e.mn[0], out_min_x);
                    err_count++;
                end
                if (out_min_y !== e.mn[1])
                begin
                    $error("out_min_y expected %h got %h", e.mn[1], out_min_y);
                    err_count++;
                end
                if (out_min_z !== e.mn[2])
                begin
                    $error("out_min_z expected %h got %h", e.mn[2], out_min_z);
                    err_count++;
                end
                if (out_max_x !== e.mx[0])
                begin
                    $error("out_max_x expected %h got %h", e.mx[0], out_max_x);
                    err_count++;
                end
                if (out_max_y !== e.mx[1])
                begin
                    $error("out_max_y expected %h got %h", e.mx[1], out_max_y);
                    err_count++;
                end
                if (out_max_z !== e.mx[2])
                begin
                    $error("out_max_z expected %h got %h", e.mx[2], out_max_z);
                    err_count++;
                end
                if (divide_fault !== e.fault)
                begin
                    $error("divide_fault expected %b got %b", e.fault, divide_fault);
                    err_count++;
                end
            end
        end
    end

    // Counts cycles in which neither a request nor a result moves.
    always @(posedge clk)
    begin
        if (!rst_n || (start && busy === 1'b0) || done === 1'b1)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    initial
    begin
        matrix_shadow[0] = 64'd65536;
        matrix_shadow[1] = 64'd0;
        matrix_shadow[2] = 64'd281474976710656;
        matrix_shadow[3] = 64'd0;
        matrix_shadow[4] = 64'd0;
        matrix_shadow[5] = 64'd65536;
        matrix_shadow[6] = 64'd0;
        matrix_shadow[7] = 64'd281474976710656;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_identity_directed();
        test_matrix_extremes();
        test_random_matrices();
        drain();
        if (err_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end
endmodule
`default_nettype wire
